FILE: hdl/cfme_pkg.sv
// shared types and constants for the card frame match and enroll core
package cfme_pkg;

   // table size and derived widths
   localparam int TABLE_ENTRIES = 4;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   // frame layout
   localparam int HDR_LEN = 7;
   localparam int POS_W = 4;
   localparam logic [POS_W-1:0] POS_HDR_END = POS_W'(HDR_LEN);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(10);
   localparam logic [7:0] HDR_BYTES [0:HDR_LEN-1] = '{
      8'h04, 8'h0c, 8'h02, 8'h30, 8'h00, 8'h04, 8'h00
   };

   // lock modes
   localparam logic [1:0] MODE_VERIFY = 2'd0;
   localparam logic [1:0] MODE_ENROLL = 2'd1;

   // result codes
   localparam logic [1:0] OUT_GRANTED = 2'd0;
   localparam logic [1:0] OUT_DENIED = 2'd1;
   localparam logic [1:0] OUT_ENROLLED = 2'd2;
   localparam logic [1:0] OUT_SKIPPED = 2'd3;

   // frame tracker to top: completed frame info
   typedef struct packed {
      logic last;
      logic [31:0] id;
   } frame_info_type;

   // card table to top: lookup status
   typedef struct packed {
      logic hit;
      logic full;
   } table_status_type;

endpackage

FILE: hdl/cfme_frame.sv
// frame tracker: header match and identifier byte capture
module cfme_frame (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              rx_byte,
   output cfme_pkg::frame_info_type frame
);
   import cfme_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       id_bytes_ff [0:2];
   logic [7:0]       id_bytes_in [0:2];
   logic [1:0]       id_sel;

   assign id_sel = 2'(pos_ff - POS_HDR_END);

   // next position and captured id bytes
   always_comb begin
      pos_in = pos_ff;
      id_bytes_in = id_bytes_ff;
      if (pos_ff < POS_HDR_END) begin
         if (rx_byte == HDR_BYTES[pos_ff[2:0]]) begin
            pos_in = pos_ff + POS_W'(1);
         end else begin
            pos_in = '0;
         end
      end else if (pos_ff < POS_LAST) begin
         id_bytes_in[id_sel] = rx_byte;
         pos_in = pos_ff + POS_W'(1);
      end else begin
         pos_in = '0;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         id_bytes_ff <= '{8'h00, 8'h00, 8'h00};
      end else if (step) begin
         pos_ff <= pos_in;
         id_bytes_ff <= id_bytes_in;
      end
   end

   // frame completes on the last identifier byte
   assign frame.last = (pos_ff == POS_LAST);
   assign frame.id = {id_bytes_ff[0], id_bytes_ff[1], id_bytes_ff[2], rx_byte};

endmodule

FILE: hdl/cfme_table.sv
// card table: enrolled ids, fill count and parallel lookup
module cfme_table (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enroll_we,
   input  logic [31:0]               card_id,
   output cfme_pkg::table_status_type status
);
   import cfme_pkg::*;

   logic [31:0]      table_ff [0:TABLE_ENTRIES-1];
   logic [CNT_W-1:0] count_ff;
   logic             hit;

   // compare against every filled entry at once
   always_comb begin
      hit = 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if ((CNT_W'(i) < count_ff) && (table_ff[i] == card_id)) begin
            hit = 1'b1;
         end
      end
   end

   assign status.hit = hit;
   assign status.full = (count_ff == CNT_W'(TABLE_ENTRIES));

   // fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (enroll_we) begin
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   // entry storage, no reset
   always_ff @(posedge clock) begin
      if (enroll_we) begin
         table_ff[count_ff[IDX_W-1:0]] <= card_id;
      end
   end

endmodule

FILE: hdl/card_frame_match_and_enroll_core.sv
// top level: input word register, frame/table logic, result register
// Takes one reader byte per cycle with the lock mode alongside it, while the
// result register is free or draining. A word is resolved while it sits in
// the input register and its result is loaded into the result register when
// the input register steps; a new word is taken every cycle while the result
// register drains. Each completed seven-byte header plus four id bytes yields
// one result in verify or enroll mode and none in other modes.
// The enrolled-card compare covers all table entries in parallel, so the
// table size does not change the rate. The table is empty after reset.
module card_frame_match_and_enroll_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic [1:0]  req_lock_mode,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_card_id,
   output logic [1:0]  rsp_outcome
);
   import cfme_pkg::*;

   logic             in_valid_ff;
   logic [7:0]       rx_byte_ff;
   logic [1:0]       lock_mode_ff;
   logic             step;
   logic             enroll_we;
   logic             emit;
   logic [1:0]       outcome_in;
   logic             rsp_valid_ff;
   logic [31:0]      card_id_ff;
   logic [1:0]       outcome_ff;
   frame_info_type   frame;
   table_status_type status;

   // stage advances when the result register is free or draining
   assign step = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   // input word register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         rx_byte_ff <= req_rx_byte;
         lock_mode_ff <= req_lock_mode;
      end
   end

   cfme_frame u_frame (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (rx_byte_ff),
      .frame   (frame)
   );

   assign enroll_we = step && frame.last && (lock_mode_ff == MODE_ENROLL) && !status.full;

   cfme_table u_table (
      .clock     (clock),
      .reset     (reset),
      .enroll_we (enroll_we),
      .card_id   (frame.id),
      .status    (status)
   );

   // outcome decode
   assign emit = frame.last && ((lock_mode_ff == MODE_VERIFY) || (lock_mode_ff == MODE_ENROLL));

   always_comb begin
      case (lock_mode_ff)
         MODE_VERIFY: outcome_in = status.hit ? OUT_GRANTED : OUT_DENIED;
         MODE_ENROLL: outcome_in = status.full ? OUT_SKIPPED : OUT_ENROLLED;
         default:     outcome_in = OUT_DENIED;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= emit;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         card_id_ff <= frame.id;
         outcome_ff <= outcome_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_card_id = card_id_ff;
   assign rsp_outcome = outcome_ff;

endmodule
